// ===== rtl/tzht_pkg.sv =====
// Package for the three-zone hysteresis thermostat.
// Holds field widths, register indexes, status codes and the shared threshold type.
// No dependencies.
`default_nettype none

package tzht_pkg;

  localparam int unsigned TempW   = 8;
  localparam int unsigned CookW   = 10;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 10;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_COOK_MINUTES = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TARGET_TEMP  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_LOW_ON_BELOW = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_LOW_OFF_AT   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MID_ON_BELOW = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_MID_OFF_AT   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_TOP_ON_BELOW = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_TOP_OFF_AT   = 3'd7;

  // Run status codes reported with each result.
  localparam logic [StatusW-1:0] STATUS_IDLE    = 2'd0;
  localparam logic [StatusW-1:0] STATUS_RUNNING = 2'd1;
  localparam logic [StatusW-1:0] STATUS_ENDED   = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [CookW-1:0] COOK_MINUTES_RST = 10'd45;
  localparam logic [TempW-1:0] TARGET_TEMP_RST  = 8'd100;
  localparam logic [TempW-1:0] LOW_ON_RST       = 8'd92;
  localparam logic [TempW-1:0] LOW_OFF_RST      = 8'd94;
  localparam logic [TempW-1:0] MID_ON_RST       = 8'd95;
  localparam logic [TempW-1:0] MID_OFF_RST      = 8'd98;
  localparam logic [TempW-1:0] TOP_ON_RST       = 8'd99;
  localparam logic [TempW-1:0] TOP_OFF_RST      = 8'd101;

  // Hysteresis thresholds of one heater zone.
  typedef struct packed {
    logic [TempW-1:0] on_below;
    logic [TempW-1:0] off_at;
  } zone_thr_t;

endpackage

`default_nettype wire

// ===== rtl/tzht_zone.sv =====
// Hysteresis decision for one heater zone.
// Depends on tzht_pkg for the threshold struct and temperature width.
`default_nettype none

module tzht_zone (
  input  logic                     active_i,
  input  logic                     relay_i,
  input  logic [tzht_pkg::TempW-1:0] temp_i,
  input  tzht_pkg::zone_thr_t      thr_i,
  output logic                     relay_o
);
  import tzht_pkg::*;

  // The on test is checked first, so it wins when thresholds overlap.
  always_comb begin
    if (!active_i) begin
      relay_o = 1'b0;
    end else if (temp_i < thr_i.on_below) begin
      relay_o = 1'b1;
    end else if (temp_i >= thr_i.off_at) begin
      relay_o = 1'b0;
    end else begin
      relay_o = relay_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/three_zone_hysteresis_thermostat_unit.sv =====
// Top level of the three-zone hysteresis thermostat with cooking timer.
// Depends on tzht_pkg and instantiates tzht_zone three times.
`default_nettype none

// Each input transaction carries one temperature sample together with the
// start, cancel and minute-tick flags, and yields exactly one result
// transaction with the three relay drives, the remaining minutes and the run
// status. An accepted transaction lands in an input register; when it
// advances, the comparisons and the timer update run in one short
// combinational pass and the result is captured in the output register, at
// which point the run state (running flag, elapsed minutes, relay states) is
// updated. One transaction per clock is sustained while results are taken.
// The input side keeps accepting while a finished result waits, and stalls
// only when both the input and output registers are full and the waiting
// result is not being taken.
// The eight setup registers are written through the cfg port, which is
// always ready; write them only while no transaction is in flight. The
// elapsed-minute counter is TIME_BITS wide and saturates at its maximum.

module three_zone_hysteresis_thermostat_unit #(
  parameter int unsigned TIME_BITS = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Sample channel.
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           start_req_i,
  input  logic [tzht_pkg::TempW-1:0]     temperature_i,
  input  logic                           cancel_i,
  input  logic                           minute_tick_i,
  // Result channel.
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           heater_low_o,
  output logic                           heater_mid_o,
  output logic                           heater_top_o,
  output logic [tzht_pkg::CookW-1:0]     minutes_left_o,
  output logic [tzht_pkg::StatusW-1:0]   run_status_o,
  // Configuration write channel.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tzht_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tzht_pkg::CfgDataW-1:0]  cfg_data_i
);
  import tzht_pkg::*;

  // Common width for comparing the cook time against the elapsed count.
  localparam int unsigned CmpW = (TIME_BITS > CookW) ? TIME_BITS : CookW;
  localparam logic [TIME_BITS-1:0] ElapsedMax = {TIME_BITS{1'b1}};

  // ---------------------------------------------------------------------
  // Configuration registers. The port never back-pressures.
  // ---------------------------------------------------------------------
  logic [CookW-1:0] cook_minutes_q;
  logic [TempW-1:0] target_temp_q;
  zone_thr_t        low_thr_q, mid_thr_q, top_thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cook_minutes_q     <= COOK_MINUTES_RST;
      target_temp_q      <= TARGET_TEMP_RST;
      low_thr_q.on_below <= LOW_ON_RST;
      low_thr_q.off_at   <= LOW_OFF_RST;
      mid_thr_q.on_below <= MID_ON_RST;
      mid_thr_q.off_at   <= MID_OFF_RST;
      top_thr_q.on_below <= TOP_ON_RST;
      top_thr_q.off_at   <= TOP_OFF_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_COOK_MINUTES: cook_minutes_q     <= cfg_data_i;
        REG_TARGET_TEMP:  target_temp_q      <= cfg_data_i[TempW-1:0];
        REG_LOW_ON_BELOW: low_thr_q.on_below <= cfg_data_i[TempW-1:0];
        REG_LOW_OFF_AT:   low_thr_q.off_at   <= cfg_data_i[TempW-1:0];
        REG_MID_ON_BELOW: mid_thr_q.on_below <= cfg_data_i[TempW-1:0];
        REG_MID_OFF_AT:   mid_thr_q.off_at   <= cfg_data_i[TempW-1:0];
        REG_TOP_ON_BELOW: top_thr_q.on_below <= cfg_data_i[TempW-1:0];
        REG_TOP_OFF_AT:   top_thr_q.off_at   <= cfg_data_i[TempW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake. The input register advances into the output register
  // whenever the output register is empty or its result is being taken.
  // ---------------------------------------------------------------------
  logic in_full_q, out_full_q;
  logic advance;
  logic in_accept;

  assign advance    = in_full_q && (!out_full_q || !out_stall_i);
  assign in_stall_o = in_full_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_valid_o = out_full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q  <= 1'b0;
      out_full_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_full_q <= 1'b1;
      end else if (advance) begin
        in_full_q <= 1'b0;
      end
      if (advance) begin
        out_full_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_full_q <= 1'b0;
      end
    end
  end

  // Input register payload.
  logic             start_q, cancel_q, tick_q;
  logic [TempW-1:0] temp_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      start_q <= start_req_i;
      temp_q  <= temperature_i;
      cancel_q <= cancel_i;
      tick_q  <= minute_tick_i;
    end
  end

  // ---------------------------------------------------------------------
  // Run state and next-state computation.
  // ---------------------------------------------------------------------
  logic                 running_q, running_d;
  logic [TIME_BITS-1:0] elapsed_q, elapsed_d;
  logic                 relay_low_q, relay_mid_q, relay_top_q;
  logic                 relay_low_d, relay_mid_d, relay_top_d;
  logic [CookW-1:0]     left_d;
  logic [StatusW-1:0]   status_d;

  logic [TIME_BITS-1:0] elapsed_inc;
  logic [CmpW-1:0]      cook_ext, elapsed_ext, left_ext;
  logic                 time_up;
  logic                 below_target;
  logic                 zones_active;
  logic                 zone_low, zone_mid, zone_top;

  // A tick is counted before the end test; the count saturates.
  assign elapsed_inc = (tick_q && (elapsed_q != ElapsedMax)) ?
                       elapsed_q + 1'b1 : elapsed_q;
  assign cook_ext    = CmpW'(cook_minutes_q);
  assign elapsed_ext = CmpW'(elapsed_inc);
  assign left_ext    = (cook_ext > elapsed_ext) ? cook_ext - elapsed_ext : '0;
  assign time_up     = (left_ext == '0);

  // target + 1 in nine bits, so a target of 255 lets every sample through.
  assign below_target = ({1'b0, temp_q} < ({1'b0, target_temp_q} + 9'd1));
  assign zones_active = below_target;

  tzht_zone u_zone_low (
    .active_i (zones_active),
    .relay_i  (relay_low_q),
    .temp_i   (temp_q),
    .thr_i    (low_thr_q),
    .relay_o  (zone_low)
  );

  tzht_zone u_zone_mid (
    .active_i (zones_active),
    .relay_i  (relay_mid_q),
    .temp_i   (temp_q),
    .thr_i    (mid_thr_q),
    .relay_o  (zone_mid)
  );

  tzht_zone u_zone_top (
    .active_i (zones_active),
    .relay_i  (relay_top_q),
    .temp_i   (temp_q),
    .thr_i    (top_thr_q),
    .relay_o  (zone_top)
  );

  always_comb begin
    running_d   = running_q;
    elapsed_d   = elapsed_q;
    relay_low_d = 1'b0;
    relay_mid_d = 1'b0;
    relay_top_d = 1'b0;
    left_d      = '0;
    status_d    = STATUS_IDLE;
    priority if (start_q) begin
      // A start arms or restarts the run; the sample is ignored.
      running_d = 1'b1;
      elapsed_d = '0;
      left_d    = cook_minutes_q;
      status_d  = STATUS_RUNNING;
    end else if (running_q) begin
      elapsed_d = elapsed_inc;
      left_d    = left_ext[CookW-1:0];
      if (cancel_q || time_up) begin
        running_d = 1'b0;
        status_d  = STATUS_ENDED;
      end else begin
        relay_low_d = zone_low;
        relay_mid_d = zone_mid;
        relay_top_d = zone_top;
        status_d    = STATUS_RUNNING;
      end
    end else begin
      // Idle: relays stay off and nothing else changes.
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= 1'b0;
      elapsed_q   <= '0;
      relay_low_q <= 1'b0;
      relay_mid_q <= 1'b0;
      relay_top_q <= 1'b0;
    end else if (advance) begin
      running_q   <= running_d;
      elapsed_q   <= elapsed_d;
      relay_low_q <= relay_low_d;
      relay_mid_q <= relay_mid_d;
      relay_top_q <= relay_top_d;
    end
  end

  // Output register payload.
  logic               heater_low_q, heater_mid_q, heater_top_q;
  logic [CookW-1:0]   minutes_left_q;
  logic [StatusW-1:0] run_status_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      heater_low_q   <= relay_low_d;
      heater_mid_q   <= relay_mid_d;
      heater_top_q   <= relay_top_d;
      minutes_left_q <= left_d;
      run_status_q   <= status_d;
    end
  end

  assign heater_low_o   = heater_low_q;
  assign heater_mid_o   = heater_mid_q;
  assign heater_top_o   = heater_top_q;
  assign minutes_left_o = minutes_left_q;
  assign run_status_o   = run_status_q;

endmodule

`default_nettype wire
